FILE: rtl/gbn_pkg.sv
// Shared types, sizes and codes for the go-back-N transmit core.
// Used by every module under rtl; depends on nothing.
package gbn_pkg;

	localparam int WINDOW_SLOTS = 8;
	localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
	localparam int SLOT_BEATS   = 32;
	localparam int BEAT_W       = $clog2(SLOT_BEATS);
	localparam int SEQ_BITS     = 16;
	localparam int TIMER_W      = 24;
	localparam int TYPE_W       = 8;
	localparam int DATA_W       = 64;
	localparam int CFG_W        = 24;
	localparam int STORE_DEPTH  = WINDOW_SLOTS * SLOT_BEATS;
	localparam int ADDR_W       = SLOT_W + BEAT_W;

	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_BEAT   = 2'd2;
	localparam logic [1:0] KIND_ACK    = 2'd3;

	localparam logic [2:0] PORT_NONE       = 3'd0;
	localparam logic [2:0] PORT_TX_HEADER  = 3'd1;
	localparam logic [2:0] PORT_TX_BEAT    = 3'd2;
	localparam logic [2:0] PORT_RPL_HEADER = 3'd3;
	localparam logic [2:0] PORT_RPL_BEAT   = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_UNEXPECT  = 3'd2;
	localparam logic [2:0] ST_BUSY      = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_NACK    = 1'b1;

	typedef struct packed {
		logic [1:0]          kind;
		logic [DATA_W-1:0]   data;
		logic                last;
		logic [SEQ_BITS-1:0] seq;
		logic [TYPE_W-1:0]   ack_type;
	} item_t;

endpackage

FILE: rtl/gbn_front.sv
// Front end: accept items, split out ack fields, queue them for the back end.
// Depends on gbn_pkg.
module gbn_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  logic [1:0]     kind,
	input  logic [63:0]    data,
	input  logic           last,
	output logic           q_valid,
	output gbn_pkg::item_t q_item,
	input  logic           q_pop
);
	gbn_pkg::item_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	gbn_pkg::item_t cls;

	assign item_stall = (count_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != 2'd0);
	assign q_item     = fifo_q[rd_ptr_q];

	// classify: pull the ack sequence and type apart up front
	always_comb begin
		cls.kind     = kind;
		cls.data     = data;
		cls.last     = last;
		cls.seq      = data[gbn_pkg::TYPE_W +: gbn_pkg::SEQ_BITS];
		cls.ack_type = data[gbn_pkg::TYPE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

FILE: rtl/gbn_back.sv
// Back end: window state, timer, replay sequencer, payload store, result register.
// Depends on gbn_pkg.
module gbn_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [23:0]    cfg_data,
	input  logic           q_valid,
	input  gbn_pkg::item_t q_item,
	output logic           q_pop,
	output logic           result_valid,
	input  logic           result_stall,
	output logic [2:0]     port,
	output logic [63:0]    out_data,
	output logic           out_last,
	output logic [2:0]     status
);
	localparam int SW = gbn_pkg::SLOT_W;
	localparam int BW = gbn_pkg::BEAT_W;

	logic [gbn_pkg::TIMER_W-1:0]  timeout_q;
	logic [gbn_pkg::TYPE_W-1:0]   nack_q;

	logic                         expect_q;
	logic [gbn_pkg::SEQ_BITS-1:0] acked_q, sent_q;
	logic [SW-1:0]                head_q, rear_q;
	logic [BW:0]                  wbeat_q;
	logic [gbn_pkg::TIMER_W-1:0]  tval_q;
	logic                         tidle_q, pend_q, act_q, inpay_q;
	logic [SW-1:0]                rslot_q, rend_q;
	logic [BW-1:0]                rbeat_q;
	logic [gbn_pkg::DATA_W-1:0]   hdr_q [gbn_pkg::WINDOW_SLOTS];
	logic [BW-1:0]                len_q [gbn_pkg::WINDOW_SLOTS];
	logic [gbn_pkg::DATA_W-1:0]   store [gbn_pkg::STORE_DEPTH];

	logic                         expect_d;
	logic [gbn_pkg::SEQ_BITS-1:0] acked_d, sent_d;
	logic [SW-1:0]                head_d, rear_d;
	logic [BW:0]                  wbeat_d;
	logic [gbn_pkg::TIMER_W-1:0]  tval_d;
	logic                         tidle_d, pend_d, act_d, inpay_d;
	logic [SW-1:0]                rslot_d, rend_d;
	logic [BW-1:0]                rbeat_d;

	logic                         hdr_we, len_we, mem_we;
	logic [BW-1:0]                len_wd;
	logic [gbn_pkg::ADDR_W-1:0]   waddr, raddr;
	logic [2:0]                   port_c, status_c;
	logic [gbn_pkg::DATA_W-1:0]   data_c;
	logic                         last_c, memsel_c, fin;
	logic [gbn_pkg::SEQ_BITS:0]   limit;
	logic [SW-1:0]                diff;

	logic                         valid_s1, memsel_s1, last_s1;
	logic [2:0]                   port_s1, status_s1;
	logic [gbn_pkg::DATA_W-1:0]   data_s1, rd_s1;

	assign q_pop = q_valid && (!valid_s1 || !result_stall);

	always_comb begin
		expect_d = expect_q; acked_d = acked_q; sent_d = sent_q;
		head_d = head_q; rear_d = rear_q; wbeat_d = wbeat_q;
		tval_d = tval_q; tidle_d = tidle_q; pend_d = pend_q; act_d = act_q;
		inpay_d = inpay_q; rslot_d = rslot_q; rend_d = rend_q; rbeat_d = rbeat_q;
		hdr_we = 1'b0; len_we = 1'b0; len_wd = '1; mem_we = 1'b0;
		waddr = {rear_q, wbeat_q[BW-1:0]};
		raddr = {rslot_q, rbeat_q};
		port_c = gbn_pkg::PORT_NONE; status_c = gbn_pkg::ST_OK;
		data_c = '0; last_c = 1'b0; memsel_c = 1'b0; fin = 1'b0;
		limit = {1'b0, acked_q} + (gbn_pkg::SEQ_BITS+1)'(gbn_pkg::WINDOW_SLOTS);
		diff = SW'(q_item.seq) - SW'(acked_q);
		unique case (q_item.kind)
			gbn_pkg::KIND_TICK: begin
				if (!tidle_q) begin
					if (tval_q != '0) tval_d = tval_q - 1'b1;
					if (tval_d == '0) pend_d = 1'b1;
				end
				if (!act_q && pend_d) begin
					act_d = 1'b1; inpay_d = 1'b0;
					rslot_d = head_q; rend_d = rear_q; rbeat_d = '0;
				end
				if (act_d) begin
					if (!inpay_d) begin
						if (rslot_d == rend_d) begin
							// window drained: close replay, rearm timer
							act_d = 1'b0; pend_d = 1'b0;
							tval_d = timeout_q; tidle_d = 1'b0;
						end else begin
							port_c = gbn_pkg::PORT_RPL_HEADER;
							data_c = hdr_q[rslot_d];
							inpay_d = 1'b1; rbeat_d = '0;
						end
					end else begin
						fin = (rbeat_d == len_q[rslot_d]);
						port_c = gbn_pkg::PORT_RPL_BEAT;
						memsel_c = 1'b1; last_c = fin;
						raddr = {rslot_d, rbeat_d};
						if (fin) begin
							inpay_d = 1'b0; rbeat_d = '0; rslot_d = rslot_d + 1'b1;
						end else begin
							rbeat_d = rbeat_d + 1'b1;
						end
					end
				end
			end
			gbn_pkg::KIND_HEADER: begin
				if (expect_q) begin
					status_c = gbn_pkg::ST_UNEXPECT;
				end else if ({1'b0, sent_q} < limit) begin
					sent_d = sent_q + 1'b1;
					hdr_we = 1'b1; len_we = 1'b1; len_wd = '1;
					expect_d = 1'b1; wbeat_d = '0;
					port_c = gbn_pkg::PORT_TX_HEADER; data_c = q_item.data;
				end else begin
					status_c = gbn_pkg::ST_FULL;
				end
			end
			gbn_pkg::KIND_BEAT: begin
				if (!expect_q) begin
					status_c = gbn_pkg::ST_UNEXPECT;
				end else begin
					if (!wbeat_q[BW]) begin
						mem_we = 1'b1;
						if (q_item.last) begin
							len_we = 1'b1; len_wd = wbeat_q[BW-1:0];
						end
						wbeat_d = wbeat_q + 1'b1;
					end else begin
						status_c = gbn_pkg::ST_TOO_LONG;
					end
					port_c = gbn_pkg::PORT_TX_BEAT;
					data_c = q_item.data; last_c = q_item.last;
					if (q_item.last) begin
						expect_d = 1'b0; wbeat_d = '0; rear_d = rear_q + 1'b1;
						tval_d = timeout_q; tidle_d = 1'b0;
					end
				end
			end
			default: begin
				if (act_q) begin
					status_c = gbn_pkg::ST_BUSY;
				end else if (q_item.seq > acked_q) begin
					// advance head before taking the new acked count
					head_d = head_q + diff;
					acked_d = q_item.seq;
					tval_d = timeout_q; tidle_d = 1'b0;
					if (q_item.ack_type == nack_q) begin
						pend_d = 1'b1; act_d = 1'b1; inpay_d = 1'b0;
						rslot_d = head_d; rend_d = rear_q; rbeat_d = '0;
						tidle_d = 1'b1; tval_d = '0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && mem_we) store[waddr] <= q_item.data;
		if (q_pop) begin
			rd_s1 <= store[raddr];
			port_s1 <= port_c; status_s1 <= status_c;
			data_s1 <= data_c; last_s1 <= last_c; memsel_s1 <= memsel_c;
		end
		if (q_pop && hdr_we) hdr_q[rear_q] <= q_item.data;
		if (q_pop && len_we) len_q[rear_q] <= len_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= gbn_pkg::TIMER_W'(1000);
			nack_q    <= gbn_pkg::TYPE_W'(2);
			expect_q <= 1'b0; acked_q <= '0; sent_q <= '0;
			head_q <= '0; rear_q <= '0; wbeat_q <= '0;
			tval_q <= '0; tidle_q <= 1'b1; pend_q <= 1'b0; act_q <= 1'b0;
			inpay_q <= 1'b0; rslot_q <= '0; rend_q <= '0; rbeat_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gbn_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
					gbn_pkg::CFG_NACK:    nack_q <= cfg_data[gbn_pkg::TYPE_W-1:0];
					default: ;
				endcase
			end
			if (q_pop) begin
				expect_q <= expect_d; acked_q <= acked_d; sent_q <= sent_d;
				head_q <= head_d; rear_q <= rear_d; wbeat_q <= wbeat_d;
				tval_q <= tval_d; tidle_q <= tidle_d; pend_q <= pend_d; act_q <= act_d;
				inpay_q <= inpay_d; rslot_q <= rslot_d; rend_q <= rend_d;
				rbeat_q <= rbeat_d;
			end
			if (q_pop) valid_s1 <= 1'b1;
			else if (!result_stall) valid_s1 <= 1'b0;
		end
	end

	assign result_valid = valid_s1;
	assign port         = port_s1;
	assign out_data     = memsel_s1 ? rd_s1 : data_s1;
	assign out_last     = last_s1;
	assign status       = status_s1;

endmodule

FILE: rtl/go_back_n_retransmit_tx_core.sv
// Go-back-N transmit core: an accepted item is written to the queue, then executed
// with the store read into the result register; throughput one item per cycle while
// result_stall is low, set by the single execute stage that updates window and replay state.
// Reset (arst_n low, asynchronous) empties the queue and result register, clears
// window counts and replay state, idles the timer and loads timeout 1000, nack 2.
// Header and payload stores are not cleared; they are only read after being written.
module go_back_n_retransmit_tx_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: index 0 timeout ticks, index 1 nack type code
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	// input items
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] data,
	input  logic        last,
	// result items, one for every accepted item
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  port,
	output logic [63:0] out_data,
	output logic        out_last,
	output logic [2:0]  status
);
	logic           q_valid;
	logic           q_pop;
	gbn_pkg::item_t q_item;

	// front: take items and split ack fields; hold up to two in the queue
	gbn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.data       (data),
		.last       (last),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// back: advance window, run timer and replay, drive the result register
	gbn_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.port         (port),
		.out_data     (out_data),
		.out_last     (out_last),
		.status       (status)
	);

endmodule

FILE: bench/gbn_tx_checker.sv
`timescale 1ns / 1ps
// Checker for the go-back-N transmit core: watches the item and result channels,
// predicts every result and compares it. Depends on gbn_pkg only.
module gbn_tx_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] data,
	input  logic        last,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [2:0]  port,
	input  logic [63:0] out_data,
	input  logic        out_last,
	input  logic [2:0]  status,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic [2:0]  port;
		logic [63:0] data;
		logic        last;
		logic [2:0]  status;
	} sent_t;

	sent_t                               sent_q[$];
	logic [gbn_pkg::TIMER_W-1:0]         m_timeout;
	logic [gbn_pkg::TYPE_W-1:0]          m_nack;
	logic                                m_expect;
	logic [gbn_pkg::SEQ_BITS-1:0]        m_acked, m_sent;
	logic [gbn_pkg::SLOT_W-1:0]          m_head, m_rear, m_rslot, m_rend;
	int                                  m_wbeat, m_rbeat;
	logic [gbn_pkg::TIMER_W-1:0]         m_timer;
	logic                                m_tidle, m_pend, m_ract, m_rpay;
	logic [63:0]                         m_hdr[gbn_pkg::WINDOW_SLOTS];
	logic [63:0]                         m_bdata[gbn_pkg::STORE_DEPTH];
	logic                                m_blast[gbn_pkg::STORE_DEPTH];

	assign pending_count = sent_q.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	function automatic sent_t mk(logic [2:0] p, logic [63:0] d, logic l, logic [2:0] s);
		sent_t r;
		r.port = p; r.data = d; r.last = l; r.status = s;
		return r;
	endfunction

	function automatic sent_t replay_next();
		int idx;
		logic fin;
		if (!m_rpay) begin
			if (m_rslot == m_rend) begin
				m_ract = 1'b0; m_pend = 1'b0;
				m_timer = m_timeout; m_tidle = 1'b0;
				return mk(gbn_pkg::PORT_NONE, '0, 1'b0, gbn_pkg::ST_OK);
			end
			m_rpay = 1'b1; m_rbeat = 0;
			return mk(gbn_pkg::PORT_RPL_HEADER, m_hdr[m_rslot], 1'b0, gbn_pkg::ST_OK);
		end
		idx = int'(m_rslot) * gbn_pkg::SLOT_BEATS + m_rbeat;
		fin = m_blast[idx] || (m_rbeat == gbn_pkg::SLOT_BEATS - 1);
		replay_next = mk(gbn_pkg::PORT_RPL_BEAT, m_bdata[idx], fin, gbn_pkg::ST_OK);
		if (fin) begin
			m_rpay = 1'b0; m_rbeat = 0; m_rslot = m_rslot + 1'b1;
		end else begin
			m_rbeat++;
		end
	endfunction

	function automatic sent_t predict_send(logic [1:0] k, logic [63:0] d, logic l);
		logic [gbn_pkg::SEQ_BITS-1:0] seq;
		logic [2:0] st;
		int idx;
		case (k)
			gbn_pkg::KIND_TICK: begin
				if (!m_tidle) begin
					if (m_timer > 0) m_timer--;
					if (m_timer == 0) m_pend = 1'b1;
				end
				if (!m_ract && m_pend) begin
					m_ract = 1'b1; m_rpay = 1'b0; m_rslot = m_head; m_rend = m_rear;
					m_rbeat = 0;
				end
				if (m_ract) return replay_next();
				return mk(gbn_pkg::PORT_NONE, '0, 1'b0, gbn_pkg::ST_OK);
			end
			gbn_pkg::KIND_HEADER: begin
				if (m_expect) return mk(gbn_pkg::PORT_NONE, '0, 1'b0, gbn_pkg::ST_UNEXPECT);
				if (32'(m_sent) < 32'(m_acked) + gbn_pkg::WINDOW_SLOTS) begin
					m_sent++;
					m_hdr[m_rear] = d;
					m_expect = 1'b1; m_wbeat = 0;
					return mk(gbn_pkg::PORT_TX_HEADER, d, 1'b0, gbn_pkg::ST_OK);
				end
				return mk(gbn_pkg::PORT_NONE, '0, 1'b0, gbn_pkg::ST_FULL);
			end
			gbn_pkg::KIND_BEAT: begin
				if (!m_expect) return mk(gbn_pkg::PORT_NONE, '0, 1'b0, gbn_pkg::ST_UNEXPECT);
				st = gbn_pkg::ST_OK;
				if (m_wbeat < gbn_pkg::SLOT_BEATS) begin
					idx = int'(m_rear) * gbn_pkg::SLOT_BEATS + m_wbeat;
					m_bdata[idx] = d;
					m_blast[idx] = l;
					m_wbeat++;
				end else begin
					st = gbn_pkg::ST_TOO_LONG;
				end
				if (l) begin
					m_expect = 1'b0; m_wbeat = 0; m_rear = m_rear + 1'b1;
					m_timer = m_timeout; m_tidle = 1'b0;
				end
				return mk(gbn_pkg::PORT_TX_BEAT, d, l, st);
			end
			default: begin
				if (m_ract) return mk(gbn_pkg::PORT_NONE, '0, 1'b0, gbn_pkg::ST_BUSY);
				seq = d[8 +: gbn_pkg::SEQ_BITS];
				if (seq > m_acked) begin
					m_head = m_head + gbn_pkg::SLOT_W'(seq - m_acked);
					m_acked = seq;
					m_timer = m_timeout; m_tidle = 1'b0;
					if (d[7:0] == m_nack) begin
						m_pend = 1'b1; m_ract = 1'b1; m_rpay = 1'b0;
						m_rslot = m_head; m_rend = m_rear; m_rbeat = 0;
						m_tidle = 1'b1; m_timer = '0;
					end
				end
				return mk(gbn_pkg::PORT_NONE, '0, 1'b0, gbn_pkg::ST_OK);
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sent_t want;
		if (!arst_n) begin
			fail_count = 0;
			sent_q.delete();
			m_timeout = 24'd1000; m_nack = 8'd2;
			m_expect = 1'b0; m_acked = '0; m_sent = '0; m_head = '0; m_rear = '0;
			m_wbeat = 0; m_timer = '0; m_tidle = 1'b1; m_pend = 1'b0; m_ract = 1'b0;
			m_rpay = 1'b0; m_rslot = '0; m_rend = '0; m_rbeat = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gbn_pkg::CFG_TIMEOUT) m_timeout = cfg_data;
				else m_nack = cfg_data[7:0];
			end
			if (item_valid && !item_stall)
				sent_q.push_back(predict_send(kind, data, last));
			if (result_valid && !result_stall) begin
				if (sent_q.size() == 0) begin
					report("unexpected result", out_data, '0);
				end else begin
					want = sent_q.pop_front();
					if (port !== want.port) report("port", 64'(port), 64'(want.port));
					if (out_data !== want.data) report("out_data", out_data, want.data);
					if (out_last !== want.last)
						report("out_last", 64'(out_last), 64'(want.last));
					if (status !== want.status)
						report("status", 64'(status), 64'(want.status));
				end
			end
		end
	end

endmodule

FILE: bench/go_back_n_retransmit_tx_core_tb.sv
`timescale 1ns / 1ps
// Top of the go-back-N transmit core bench: clock, reset, register writes and
// item stimulus. Depends on gbn_pkg, the core and gbn_tx_checker.
module go_back_n_retransmit_tx_core_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int ROUNDS         = 110;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [23:0] cfg_data = 0;
	logic        item_valid = 0;
	logic        item_stall;
	logic [1:0]  kind = 0;
	logic [63:0] data = 0;
	logic        last = 0;
	logic        result_valid;
	logic        result_stall = 0;
	logic [2:0]  port;
	logic [63:0] out_data;
	logic        out_last;
	logic [2:0]  status;
	int          fail_count, pending_count;
	int          idle_cycles = 0;
	bit          calm = 0;
	// software view of the window, used to build acks that stay legal
	int          acked_seq = 0;
	// headers seen sent on the result side; never above the core's sent count
	int          hdr_results = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	go_back_n_retransmit_tx_core u_top (.*);

	gbn_tx_checker u_chk (.*);

	// Stall results in random bursts; none once the calm phase starts.
	initial begin
		int n;
		forever begin
			n = $urandom_range(1, 14);
			repeat (n) @(posedge clk);
			result_stall <= !calm && ($urandom_range(0, 3) == 0);
		end
	end

	// Count headers that actually went out, to bound ack sequences.
	always @(posedge clk) begin
		if (result_valid && !result_stall && port == gbn_pkg::PORT_TX_HEADER)
			hdr_results <= hdr_results + 1;
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("go_back_n_retransmit_tx_core_tb: FAIL");
			$finish;
		end
	end

	// Present one item and hold it until accepted; maybe leave a gap after.
	task automatic send_item(input logic [1:0] k, input logic [63:0] d, input logic l);
		item_valid <= 1;
		kind <= k;
		data <= d;
		last <= l;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [23:0] v);
		item_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Send one packet: header, then beats; long packets overrun the slot.
	task automatic send_packet(input int beats);
		send_item(gbn_pkg::KIND_HEADER, rand64(), 1'b0);
		for (int b = 0; b < beats; b++)
			send_item(gbn_pkg::KIND_BEAT, rand64(), b == beats - 1);
	endtask

	// Ack up to some sequence no further than what has been sent.
	task automatic send_ack(input bit as_nack, input logic [7:0] nack);
		logic [63:0] w;
		int s;
		s = acked_seq + int'($urandom_range(0, hdr_results - acked_seq));
		w = rand64();
		w[8 +: gbn_pkg::SEQ_BITS] = gbn_pkg::SEQ_BITS'(s);
		if (as_nack) w[7:0] = nack;
		else if (w[7:0] == nack) w[7:0] = nack + 8'd1;
		send_item(gbn_pkg::KIND_ACK, w, 1'b0);
		// an ack refused during replay leaves the count alone; be conservative
		if (s > acked_seq) acked_seq = s;
	endtask

	initial begin
		int r;
		logic [7:0] nack;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: default timeout, errors, extremes, window full, nack.
		nack = 8'd2;
		send_item(gbn_pkg::KIND_BEAT, '1, 1'b1);
		send_item(gbn_pkg::KIND_HEADER, '0, 1'b0);
		send_item(gbn_pkg::KIND_HEADER, '1, 1'b0);
		send_item(gbn_pkg::KIND_BEAT, '1, 1'b0);
		send_item(gbn_pkg::KIND_BEAT, '0, 1'b1);
		send_packet(34);
		for (int p = 0; p < 7; p++) send_packet(1);
		send_item(gbn_pkg::KIND_HEADER, rand64(), 1'b0);
		send_ack(1, nack);
		repeat (6) send_item(gbn_pkg::KIND_TICK, '0, 1'b0);
		send_item(gbn_pkg::KIND_ACK, 64'h0, 1'b0);

		write_reg(gbn_pkg::CFG_TIMEOUT, 24'd0);
		write_reg(gbn_pkg::CFG_NACK, 24'hff);
		nack = 8'hff;
		// drain any replay before acking
		repeat (40) send_item(gbn_pkg::KIND_TICK, '0, 1'b0);

		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 1) begin
				write_reg(gbn_pkg::CFG_TIMEOUT, 24'hffffff);
				write_reg(gbn_pkg::CFG_NACK, 24'h00);
				nack = 8'h00;
			end else if (phase == 2) begin
				write_reg(gbn_pkg::CFG_TIMEOUT, 24'd1);
				write_reg(gbn_pkg::CFG_NACK, 24'h5a);
				nack = 8'h5a;
			end else if (phase == 3) begin
				write_reg(gbn_pkg::CFG_TIMEOUT, 24'd6);
				calm = 1;
			end
			for (int i = 0; i < ROUNDS; i++) begin
				r = $urandom_range(0, 9);
				if (hdr_results >= 60000) send_item(gbn_pkg::KIND_TICK, '0, 1'b0);
				else if (r < 3) send_packet($urandom_range(0, 7) == 0 ?
						$urandom_range(30, 35) : $urandom_range(1, 3));
				else if (r < 5) send_ack($urandom_range(0, 3) == 0, nack);
				else if (r < 9) send_item(gbn_pkg::KIND_TICK, '0, 1'b0);
				else send_item(2'($urandom_range(1, 2)), rand64(),
						1'($urandom_range(0, 1)));
			end
		end

		item_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("go_back_n_retransmit_tx_core_tb: PASS");
		else
			$display("go_back_n_retransmit_tx_core_tb: FAIL");
		$finish;
	end

endmodule

FILE: go_back_n_retransmit_tx_core.f
rtl/gbn_pkg.sv
rtl/gbn_front.sv
rtl/gbn_back.sv
rtl/go_back_n_retransmit_tx_core.sv
bench/gbn_tx_checker.sv
bench/go_back_n_retransmit_tx_core_tb.sv
